// ===== rtl/stl_pkg.sv =====
// stl_pkg: shared types, widths and codes for the symbol table lookup core
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package stl_pkg;

	// fixed field widths of the item channels
	localparam int CMD_W     = 2;
	localparam int ADDR_W    = 12;
	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 7;
	localparam int NODE_W    = 12;
	localparam int STATUS_W  = 2;
	localparam int IDX_OUT_W = 6;

	// default sizing
	localparam int BUFFER_DEPTH_DEF    = 4096;
	localparam int TABLE_ENTRIES_DEF   = 64;
	localparam int MAX_NAME_LENGTH_DEF = 64;

	typedef enum logic [CMD_W-1:0] {
		CMD_WRITE  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_SEARCH = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	// which result the datapath latches
	typedef enum logic [2:0] {
		RES_NONE,
		RES_ZERO,
		RES_FULL,
		RES_MISS,
		RES_HIT,
		RES_APPEND
	} res_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_REDUCE,
		S_APPEND,
		S_ENTRY_RD,
		S_ENTRY_CHK,
		S_CHAR_RD,
		S_CHAR_CHK,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic     load;
		logic     buf_wr;
		logic     red_step;
		logic     clr_count;
		logic     ent_wr;
		logic     ent_next;
		logic     char_init;
		logic     char_step;
		res_sel_t res_sel;
		logic     push;
	} dp_cmd_t;

	typedef struct packed {
		cmd_t cmd;
		logic full;
		logic red_last;
		logic scan_end;
		logic len_match;
		logic len_zero;
		logic byte_match;
		logic char_last;
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/stl_ifs.sv =====
// stl_req_if and stl_rsp_if: valid/ready channels for command and result items
// depends on stl_pkg
`timescale 1ns / 1ps
`default_nettype none

interface stl_req_if;
	logic                          valid;
	logic                          ready;
	logic [stl_pkg::CMD_W-1:0]     command;
	logic [stl_pkg::ADDR_W-1:0]    buffer_address;
	logic [stl_pkg::BYTE_W-1:0]    buffer_byte;
	logic [stl_pkg::ADDR_W-1:0]    name_start;
	logic [stl_pkg::LEN_W-1:0]     name_length;
	logic [stl_pkg::NODE_W-1:0]    node_index;

	modport source (
		output valid, command, buffer_address, buffer_byte, name_start, name_length,
			node_index,
		input  ready
	);
	modport sink (
		input  valid, command, buffer_address, buffer_byte, name_start, name_length,
			node_index,
		output ready
	);
endinterface

interface stl_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [stl_pkg::STATUS_W-1:0]  status;
	logic [stl_pkg::IDX_OUT_W-1:0] entry_index;
	logic [stl_pkg::NODE_W-1:0]    found_node;

	modport source (
		output valid, status, entry_index, found_node,
		input  ready
	);
	modport sink (
		input  valid, status, entry_index, found_node,
		output ready
	);
endinterface

`default_nettype wire

// ===== rtl/stl_ram.sv =====
// stl_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module stl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

// ===== rtl/stl_ctrl.sv =====
// stl_ctrl: sequencer for write, append, search and clear commands
// depends on stl_pkg; drives stl_dpath through dp_cmd_t, reads dp_stat_t
`timescale 1ns / 1ps
`default_nettype none

module stl_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire stl_pkg::dp_stat_t stat,
	output stl_pkg::dp_cmd_t       cmd
);
	import stl_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		cmd.res_sel = RES_NONE;
		req_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (stat.cmd)
					CMD_WRITE: begin
						cmd.buf_wr  = 1'b1;
						cmd.res_sel = RES_ZERO;
						state_d     = S_FINISH;
					end
					CMD_CLEAR: begin
						cmd.clr_count = 1'b1;
						cmd.res_sel   = RES_ZERO;
						state_d       = S_FINISH;
					end
					CMD_APPEND: begin
						if (stat.full) begin
							cmd.res_sel = RES_FULL;
							state_d     = S_FINISH;
						end else begin
							state_d = S_REDUCE;
						end
					end
					CMD_SEARCH: begin
						state_d = S_REDUCE;
					end
				endcase
			end
			S_REDUCE: begin
				// fold the start position into the buffer range
				cmd.red_step = 1'b1;
				if (stat.red_last) begin
					state_d = (stat.cmd == CMD_APPEND) ? S_APPEND : S_ENTRY_RD;
				end
			end
			S_APPEND: begin
				cmd.ent_wr  = 1'b1;
				cmd.res_sel = RES_APPEND;
				state_d     = S_FINISH;
			end
			S_ENTRY_RD: begin
				if (stat.scan_end) begin
					cmd.res_sel = RES_MISS;
					state_d     = S_FINISH;
				end else begin
					state_d = S_ENTRY_CHK;
				end
			end
			S_ENTRY_CHK: begin
				priority if (!stat.len_match) begin
					cmd.ent_next = 1'b1;
					state_d      = S_ENTRY_RD;
				end else if (stat.len_zero) begin
					cmd.res_sel = RES_HIT;
					state_d     = S_FINISH;
				end else begin
					cmd.char_init = 1'b1;
					state_d       = S_CHAR_RD;
				end
			end
			S_CHAR_RD: begin
				cmd.char_step = 1'b1;
				state_d       = S_CHAR_CHK;
			end
			S_CHAR_CHK: begin
				priority if (!stat.byte_match) begin
					cmd.ent_next = 1'b1;
					state_d      = S_ENTRY_RD;
				end else if (stat.char_last) begin
					cmd.res_sel = RES_HIT;
					state_d     = S_FINISH;
				end else begin
					state_d = S_CHAR_RD;
				end
			end
			S_FINISH: begin
				// wait for the output register to free up
				if (stat.out_free) begin
					cmd.push = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== rtl/stl_dpath.sv =====
// stl_dpath: item registers, char buffer and entry table rams, scan counters,
// result and output registers; depends on stl_pkg and stl_ram
`timescale 1ns / 1ps
`default_nettype none

module stl_dpath #(
	parameter int BUFFER_DEPTH    = stl_pkg::BUFFER_DEPTH_DEF,
	parameter int TABLE_ENTRIES   = stl_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_NAME_LENGTH = stl_pkg::MAX_NAME_LENGTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic [stl_pkg::CMD_W-1:0]     command,
	input  wire logic [stl_pkg::ADDR_W-1:0]    buffer_address,
	input  wire logic [stl_pkg::BYTE_W-1:0]    buffer_byte,
	input  wire logic [stl_pkg::ADDR_W-1:0]    name_start,
	input  wire logic [stl_pkg::LEN_W-1:0]     name_length,
	input  wire logic [stl_pkg::NODE_W-1:0]    node_index,
	input  wire stl_pkg::dp_cmd_t              cmd,
	output stl_pkg::dp_stat_t                  stat,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [stl_pkg::STATUS_W-1:0]       status,
	output logic [stl_pkg::IDX_OUT_W-1:0]      entry_index,
	output logic [stl_pkg::NODE_W-1:0]         found_node
);
	import stl_pkg::*;

	localparam int BA_W  = $clog2(BUFFER_DEPTH);
	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int EW    = BA_W + LEN_W + NODE_W;
	// reciprocal of the buffer depth, exact quotient for any 12-bit start
	localparam int RSH   = 2 * ADDR_W;
	localparam int RCP_W = RSH + 1 - $clog2(BUFFER_DEPTH);
	localparam int DEP_W = $clog2(BUFFER_DEPTH + 1);
	localparam int PRD_W = ADDR_W + RCP_W;
	localparam int BCK_W = ADDR_W + DEP_W;
	localparam logic [RCP_W-1:0] RECIP =
		RCP_W'(((1 << RSH) + BUFFER_DEPTH - 1) / BUFFER_DEPTH);
	localparam logic [DEP_W-1:0] DEPTH_C = DEP_W'(BUFFER_DEPTH);

	// item registers
	cmd_t              cmd_q;
	logic [BA_W-1:0]   wr_addr_q;
	logic [BYTE_W-1:0] wr_byte_q;
	logic              wr_ok_q;
	logic [ADDR_W-1:0] red_q;
	logic              red_k_q;
	logic [ADDR_W-1:0] quo_q;
	logic [LEN_W-1:0]  len_q;
	logic [NODE_W-1:0] node_q;

	// scan state
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  ent_i_q;
	logic [BA_W-1:0]   qptr_q;
	logic [BA_W-1:0]   eptr_q;
	logic [LEN_W-1:0]  chr_j_q;

	// result and output
	status_t              res_status_q;
	logic [IDX_OUT_W-1:0] res_idx_q;
	logic [NODE_W-1:0]    res_node_q;
	logic                 out_valid_q;
	status_t              out_status_q;
	logic [IDX_OUT_W-1:0] out_idx_q;
	logic [NODE_W-1:0]    out_node_q;

	logic [LEN_W-1:0]  len_in;
	logic [PRD_W-1:0]  red_prod;
	logic [BCK_W-1:0]  red_back;
	logic [EW-1:0]     ent_rd;
	logic [BA_W-1:0]   ent_start;
	logic [LEN_W-1:0]  ent_len;
	logic [NODE_W-1:0] ent_node;
	logic [BYTE_W-1:0] qbyte;
	logic [BYTE_W-1:0] ebyte;
	logic [BA_W-1:0]   qptr_nxt;
	logic [BA_W-1:0]   eptr_nxt;
	logic              buf_we;

	assign len_in  = (int'(name_length) > MAX_NAME_LENGTH) ? LEN_W'(MAX_NAME_LENGTH)
		: name_length;
	assign red_prod = PRD_W'(red_q) * PRD_W'(RECIP);
	assign red_back = BCK_W'(quo_q) * BCK_W'(DEPTH_C);

	assign ent_start = ent_rd[EW-1 -: BA_W];
	assign ent_len   = ent_rd[NODE_W +: LEN_W];
	assign ent_node  = ent_rd[NODE_W-1:0];

	// buffer positions wrap at the buffer end
	assign qptr_nxt = (qptr_q == BA_W'(BUFFER_DEPTH - 1)) ? '0 : qptr_q + 1'b1;
	assign eptr_nxt = (eptr_q == BA_W'(BUFFER_DEPTH - 1)) ? '0 : eptr_q + 1'b1;

	assign buf_we = cmd.buf_wr && wr_ok_q;

	// two copies of the buffer give one query and one entry byte per read
	stl_ram #(.WIDTH(BYTE_W), .DEPTH(BUFFER_DEPTH)) u_qbuf (
		.clk     (clk),
		.wr_en   (buf_we),
		.wr_addr (wr_addr_q),
		.wr_data (wr_byte_q),
		.rd_addr (qptr_q),
		.rd_data (qbyte)
	);

	stl_ram #(.WIDTH(BYTE_W), .DEPTH(BUFFER_DEPTH)) u_ebuf (
		.clk     (clk),
		.wr_en   (buf_we),
		.wr_addr (wr_addr_q),
		.wr_data (wr_byte_q),
		.rd_addr (eptr_q),
		.rd_data (ebyte)
	);

	stl_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_table (
		.clk     (clk),
		.wr_en   (cmd.ent_wr),
		.wr_addr (cnt_q[IDX_W-1:0]),
		.wr_data ({BA_W'(red_q), len_q, node_q}),
		.rd_addr (ent_i_q[IDX_W-1:0]),
		.rd_data (ent_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_count) begin
				cnt_q <= '0;
			end else if (cmd.ent_wr) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q     <= cmd_t'(command);
			wr_addr_q <= BA_W'(buffer_address);
			wr_byte_q <= buffer_byte;
			wr_ok_q   <= int'(buffer_address) < BUFFER_DEPTH;
			red_q     <= name_start;
			red_k_q   <= 1'b1;
			len_q     <= len_in;
			node_q    <= node_index;
			ent_i_q   <= '0;
		end
		if (cmd.red_step) begin
			// the first step takes the quotient, the second subtracts quotient times depth
			if (red_k_q) begin
				quo_q <= ADDR_W'(red_prod >> RSH);
			end else begin
				red_q <= red_q - ADDR_W'(red_back);
			end
			red_k_q <= 1'b0;
		end
		if (cmd.ent_next) begin
			ent_i_q <= ent_i_q + 1'b1;
		end
		if (cmd.char_init) begin
			qptr_q  <= BA_W'(red_q);
			eptr_q  <= ent_start;
			chr_j_q <= '0;
		end
		if (cmd.char_step) begin
			qptr_q  <= qptr_nxt;
			eptr_q  <= eptr_nxt;
			chr_j_q <= chr_j_q + 1'b1;
		end
		unique case (cmd.res_sel)
			RES_ZERO: begin
				res_status_q <= STAT_OK;
				res_idx_q    <= '0;
				res_node_q   <= '0;
			end
			RES_FULL: begin
				res_status_q <= STAT_FULL;
				res_idx_q    <= '0;
				res_node_q   <= '0;
			end
			RES_MISS: begin
				res_status_q <= STAT_MISS;
				res_idx_q    <= '0;
				res_node_q   <= '0;
			end
			RES_HIT: begin
				res_status_q <= STAT_OK;
				res_idx_q    <= IDX_OUT_W'(ent_i_q);
				res_node_q   <= ent_node;
			end
			RES_APPEND: begin
				res_status_q <= STAT_OK;
				res_idx_q    <= IDX_OUT_W'(cnt_q);
				res_node_q   <= node_q;
			end
			default: begin
			end
		endcase
		if (cmd.push) begin
			out_status_q <= res_status_q;
			out_idx_q    <= res_idx_q;
			out_node_q   <= res_node_q;
		end
	end

	always_comb begin
		stat.cmd        = cmd_q;
		stat.full       = cnt_q == CNT_W'(TABLE_ENTRIES);
		stat.red_last   = !red_k_q;
		stat.scan_end   = ent_i_q == cnt_q;
		stat.len_match  = ent_len == len_q;
		stat.len_zero   = len_q == '0;
		stat.byte_match = qbyte == ebyte;
		stat.char_last  = chr_j_q == len_q;
		stat.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid   = out_valid_q;
	assign status      = out_status_q;
	assign entry_index = out_idx_q;
	assign found_node  = out_node_q;

endmodule

`default_nettype wire

// ===== rtl/symbol_table_name_lookup_core.sv =====
// write and clear go from decode straight to the result, as does append to a full table;
// append folds the start, then writes the entry; search folds it, then compares entries
// the start fold is a reciprocal multiply, then a subtract
// one item at a time; a new item is taken while the previous result waits
// reset clears the entry count and the output valid; buffer and table are
// undefined until written, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module symbol_table_name_lookup_core #(
	parameter int BUFFER_DEPTH    = stl_pkg::BUFFER_DEPTH_DEF,
	parameter int TABLE_ENTRIES   = stl_pkg::TABLE_ENTRIES_DEF,
	parameter int MAX_NAME_LENGTH = stl_pkg::MAX_NAME_LENGTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	stl_req_if.sink    req,
	stl_rsp_if.source  rsp
);
	import stl_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     req_ready;

	assign req.ready = req_ready;

	stl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	stl_dpath #(
		.BUFFER_DEPTH    (BUFFER_DEPTH),
		.TABLE_ENTRIES   (TABLE_ENTRIES),
		.MAX_NAME_LENGTH (MAX_NAME_LENGTH)
	) u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.command        (req.command),
		.buffer_address (req.buffer_address),
		.buffer_byte    (req.buffer_byte),
		.name_start     (req.name_start),
		.name_length    (req.name_length),
		.node_index     (req.node_index),
		.cmd            (cmd),
		.stat           (stat),
		.out_valid      (rsp.valid),
		.out_ready      (rsp.ready),
		.status         (rsp.status),
		.entry_index    (rsp.entry_index),
		.found_node     (rsp.found_node)
	);

`ifndef SYNTHESIS
	// one item in work at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> !req.ready)
		else $error("item accepted while another is in work");

	// a result is never pushed over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> stat.out_free)
		else $error("result pushed into a full output register");

	// an append never writes past the table
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ent_wr |-> !stat.full)
		else $error("entry written into a full table");
`endif

endmodule

`default_nettype wire
